>>> rtl/bcp_pkg.sv
// bcp_pkg: shared types, register codes and fixed-point helpers for the
// box corner projector; no dependencies
package bcp_pkg;

  localparam int WORD_W = 32;
  localparam int CFG_W  = 64;
  localparam int DIM_W  = 15;
  localparam int IDX_W  = 3;

  // configuration register codes
  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_FIRST    = 3'd0,
    REG_ROW_X_SECOND   = 3'd1,
    REG_ROW_Y_FIRST    = 3'd2,
    REG_ROW_Y_SECOND   = 3'd3,
    REG_ROW_W_FIRST    = 3'd4,
    REG_ROW_W_SECOND   = 3'd5,
    REG_DISPLAY_WIDTH  = 3'd6,
    REG_DISPLAY_HEIGHT = 3'd7
  } reg_idx_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic             valid;
    logic             vis;
    logic [IDX_W-1:0] idx;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
  } div_side_t;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  // clamp a 64-bit signed value to 32 bits
  function automatic logic signed [WORD_W-1:0] sat64(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = S32_MAX;
    else if (v < -64'sh0000_0000_8000_0000) r = S32_MIN;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

  // one restoring division step, returns {quotient bit, remainder}
  function automatic logic [WORD_W:0] div_step(input logic [WORD_W-1:0] rem,
                                               input logic b,
                                               input logic [WORD_W-1:0] d);
    logic [WORD_W:0] r2;
    logic [WORD_W:0] r;
    r2 = {rem, b};
    if (r2 >= {1'b0, d}) begin
      r2 = r2 - {1'b0, d};
      r  = {1'b1, r2[WORD_W-1:0]};
    end else begin
      r  = {1'b0, r2[WORD_W-1:0]};
    end
    return r;
  endfunction

  // signed quotient from magnitude, sign and overflow flag
  function automatic logic signed [WORD_W-1:0] sat_quot(input logic [WORD_W-1:0] q,
                                                        input logic neg,
                                                        input logic ovf);
    logic signed [WORD_W-1:0] r;
    if (ovf) r = neg ? S32_MIN : S32_MAX;
    else if (!neg) r = q[WORD_W-1] ? S32_MAX : $signed(q);
    else if (q > 32'h8000_0000) r = S32_MIN;
    else r = $signed(-q);
    return r;
  endfunction

endpackage

>>> rtl/bcp_if.sv
// bcp_if: valid/ready channels for box words and corner words
// depends on nothing
interface bcp_box_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] low_extent_x;
  logic signed [31:0] low_extent_y;
  logic signed [31:0] low_extent_z;
  logic signed [31:0] high_extent_z;
  modport source (output valid, origin_x, origin_y, origin_z, low_extent_x,
                  low_extent_y, low_extent_z, high_extent_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, low_extent_x,
                low_extent_y, low_extent_z, high_extent_z, output ready);
endinterface

interface bcp_corner_if;
  logic              valid;
  logic              ready;
  logic [2:0]        corner_index;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic              visible;
  logic              last_corner;
  modport source (output valid, corner_index, screen_x, screen_y, visible,
                  last_corner, input ready);
  modport sink (input valid, corner_index, screen_x, screen_y, visible,
                last_corner, output ready);
endinterface

>>> rtl/box_corner_projector.sv
// box_corner_projector: projects the eight corners of a box to the screen
// depends on bcp_pkg, bcp_if and bcp_div
//
//  channel     dir  word                                          handshake
//  box_in      in   origin, low extents x/y/z, high extent z      valid/ready
//  corner_out  out  corner index, screen x/y, visible, last flag  valid/ready
//  cfg         in   write enable, index, 64-bit data              we only
//
// a box is taken as the previous box's last corner issues; boxes yield one
// corner per cycle unless the output stalls; the sequencer sets that rate.
// a corner passes stages 1 to 4, the two-bit-per-stage divider, then 5 to 7.
// rst (synchronous) clears valid bits, sequencer and rows, sets display 640x480.
// a stalled output freezes the whole pipeline; nothing is lost or repeated.
module box_corner_projector #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  bcp_pkg::reg_idx_t cfg_index,
  input  logic [63:0]       cfg_data,
  bcp_box_if.sink           box_in,
  bcp_corner_if.source      corner_out
);
  import bcp_pkg::*;

  localparam logic signed [WORD_W-1:0] THRESH =
    WORD_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // configuration registers
  logic [CFG_W-1:0] rows [0:5];
  logic [DIM_W-1:0] disp_w, disp_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) rows[i] <= '0;
      disp_w <= DIM_W'(640);
      disp_h <= DIM_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_X_FIRST:    rows[0] <= cfg_data;
        REG_ROW_X_SECOND:   rows[1] <= cfg_data;
        REG_ROW_Y_FIRST:    rows[2] <= cfg_data;
        REG_ROW_Y_SECOND:   rows[3] <= cfg_data;
        REG_ROW_W_FIRST:    rows[4] <= cfg_data;
        REG_ROW_W_SECOND:   rows[5] <= cfg_data;
        REG_DISPLAY_WIDTH:  disp_w  <= cfg_data[DIM_W-1:0];
        REG_DISPLAY_HEIGHT: disp_h  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !corner_out.valid || corner_out.ready;

  // corner sequencer
  logic                     busy;
  logic [IDX_W-1:0]         k;
  logic signed [WORD_W-1:0] ox, oy, oz, ex, ey, lz, hz;
  logic                     load;

  assign box_in.ready = en && (!busy || k == 3'd7);
  assign load = box_in.valid && box_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (en) begin
      if (load) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 3'd1;
        if (k == 3'd7) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ox <= box_in.origin_x;     oy <= box_in.origin_y;
      oz <= box_in.origin_z;     ex <= box_in.low_extent_x;
      ey <= box_in.low_extent_y; lz <= box_in.low_extent_z;
      hz <= box_in.high_extent_z;
    end
  end

  // corner coordinates
  logic signed [32:0] cx, cy, cz;
  always_comb begin
    cx = k[0] ? ({ox[31], ox} + {ex[31], ex}) : ({ox[31], ox} - {ex[31], ex});
    cy = (k[0] ^ k[1]) ? ({oy[31], oy} + {ey[31], ey}) : ({oy[31], oy} - {ey[31], ey});
    cz = k[2] ? ({oz[31], oz} + {hz[31], hz}) : ({oz[31], oz} - {lz[31], lz});
  end

  // stage 1: saturated corner
  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_idx;
  logic signed [WORD_W-1:0] s1_v [0:2];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= busy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx  <= k;
      s1_v[0] <= sat64(64'(cx));
      s1_v[1] <= sat64(64'(cy));
      s1_v[2] <= sat64(64'(cz));
    end
  end

  // stage 2: nine products
  logic                     s2_valid;
  logic [IDX_W-1:0]         s2_idx;
  logic signed [63:0]       s2_p [0:8];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_idx <= s1_idx;
      for (int r = 0; r < 3; r++) begin
        s2_p[r*3+0] <= $signed(rows[r*2][31:0])   * s1_v[0];
        s2_p[r*3+1] <= $signed(rows[r*2][63:32])  * s1_v[1];
        s2_p[r*3+2] <= $signed(rows[r*2+1][31:0]) * s1_v[2];
      end
    end
  end

  // stage 3: scaled sums plus translation
  logic                     s3_valid;
  logic [IDX_W-1:0]         s3_idx;
  logic signed [WORD_W-1:0] s3_d [0:2];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_idx <= s2_idx;
      for (int r = 0; r < 3; r++) begin
        s3_d[r] <= sat64((s2_p[r*3] >>> FRAC_BITS) + (s2_p[r*3+1] >>> FRAC_BITS)
                         + (s2_p[r*3+2] >>> FRAC_BITS)
                         + 64'($signed(rows[r*2+1][63:32])));
      end
    end
  end

  // stage 4: divider setup
  logic [WORD_W-1:0] mag_x, mag_y;
  logic [63:0]       num_x, num_y;
  assign mag_x = s3_d[0][31] ? -s3_d[0] : s3_d[0];
  assign mag_y = s3_d[1][31] ? -s3_d[1] : s3_d[1];
  assign num_x = {32'b0, mag_x} << FRAC_BITS;
  assign num_y = {32'b0, mag_y} << FRAC_BITS;

  div_side_t         s4_side;
  logic [WORD_W-1:0] s4_den, s4_rx, s4_lx, s4_ry, s4_ly;

  always_ff @(posedge clk) begin
    if (rst) s4_side.valid <= 1'b0;
    else if (en) s4_side.valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.vis   <= s3_d[2] >= THRESH;
      s4_side.idx   <= s3_idx;
      s4_side.neg_x <= s3_d[0][31];
      s4_side.neg_y <= s3_d[1][31];
      s4_side.ovf_x <= num_x[63:32] >= s3_d[2];
      s4_side.ovf_y <= num_y[63:32] >= s3_d[2];
      s4_den <= s3_d[2];
      s4_rx  <= num_x[63:32];
      s4_lx  <= num_x[31:0];
      s4_ry  <= num_y[63:32];
      s4_ly  <= num_y[31:0];
    end
  end

  div_side_t         dv_side;
  logic [WORD_W-1:0] dv_qx, dv_qy;

  bcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (s4_side),
    .den      (s4_den),
    .rem_x_in (s4_rx),
    .lo_x_in  (s4_lx),
    .rem_y_in (s4_ry),
    .lo_y_in  (s4_ly),
    .side_out (dv_side),
    .quot_x   (dv_qx),
    .quot_y   (dv_qy)
  );

  // stage 5: signed, saturated quotients
  logic                     s5_valid, s5_vis;
  logic [IDX_W-1:0]         s5_idx;
  logic signed [WORD_W-1:0] s5_sx, s5_sy;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (en) s5_valid <= dv_side.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vis <= dv_side.vis;
      s5_idx <= dv_side.idx;
      s5_sx  <= sat_quot(dv_qx, dv_side.neg_x, dv_side.ovf_x);
      s5_sy  <= sat_quot(dv_qy, dv_side.neg_y, dv_side.ovf_y);
    end
  end

  // stage 6: scale by viewport size
  logic               s6_valid, s6_vis;
  logic [IDX_W-1:0]   s6_idx;
  logic signed [47:0] s6_mx, s6_my;

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (en) s6_valid <= s5_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_vis <= s5_vis;
      s6_idx <= s5_idx;
      s6_mx  <= s5_sx * $signed({1'b0, disp_w});
      s6_my  <= s5_sy * $signed({1'b0, disp_h});
    end
  end

  // stage 7: viewport offset and output word
  logic signed [63:0] base_x, base_y, scx, scy;
  assign base_x = $signed({49'b0, disp_w}) <<< (FRAC_BITS - 1);
  assign base_y = $signed({49'b0, disp_h}) <<< (FRAC_BITS - 1);
  assign scx = base_x + (64'(s6_mx) >>> 1) + HALF;
  assign scy = base_y - ((64'(s6_my) >>> 1) + HALF);

  always_ff @(posedge clk) begin
    if (rst) corner_out.valid <= 1'b0;
    else if (en) corner_out.valid <= s6_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner_out.corner_index <= s6_idx;
      corner_out.screen_x     <= s6_vis ? sat64(scx) : '0;
      corner_out.screen_y     <= s6_vis ? sat64(scy) : '0;
      corner_out.visible      <= s6_vis;
      corner_out.last_corner  <= s6_idx == 3'd7;
    end
  end

  // checks
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    corner_out.valid |-> (corner_out.last_corner == (corner_out.corner_index == 3'd7)))
    else $error("last flag does not match corner index");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (corner_out.valid && !corner_out.visible) |->
      (corner_out.screen_x == 0 && corner_out.screen_y == 0))
    else $error("hidden corner has nonzero position");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && k == 3'd0))
    else $error("sequencer did not start on a new box");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && busy) |=> $stable(k))
    else $error("sequencer moved during a stall");

endmodule

>>> rtl/bcp_div.sv
// bcp_div: pipelined restoring divider, two lanes sharing one divisor,
// two quotient bits per stage; uses bcp_pkg
module bcp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  bcp_pkg::div_side_t        side_in,
  input  logic [31:0]               den,
  input  logic [31:0]               rem_x_in,
  input  logic [31:0]               lo_x_in,
  input  logic [31:0]               rem_y_in,
  input  logic [31:0]               lo_y_in,
  output bcp_pkg::div_side_t        side_out,
  output logic [31:0]               quot_x,
  output logic [31:0]               quot_y
);
  import bcp_pkg::*;

  localparam int STEPS  = 2;
  localparam int STAGES = WORD_W / STEPS;

  div_side_t          side  [0:STAGES];
  logic [WORD_W-1:0]  d     [0:STAGES];
  logic [WORD_W-1:0]  rem_x [0:STAGES];
  logic [WORD_W-1:0]  lo_x  [0:STAGES];
  logic [WORD_W-1:0]  q_x   [0:STAGES];
  logic [WORD_W-1:0]  rem_y [0:STAGES];
  logic [WORD_W-1:0]  lo_y  [0:STAGES];
  logic [WORD_W-1:0]  q_y   [0:STAGES];

  assign side[0]  = side_in;
  assign d[0]     = den;
  assign rem_x[0] = rem_x_in;
  assign lo_x[0]  = lo_x_in;
  assign q_x[0]   = '0;
  assign rem_y[0] = rem_y_in;
  assign lo_y[0]  = lo_y_in;
  assign q_y[0]   = '0;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [WORD_W-1:0] rx, lx, qx, ry, ly, qy;
    logic [WORD_W:0]   sx, sy;

    // two division steps per lane
    always_comb begin
      rx = rem_x[j]; lx = lo_x[j]; qx = q_x[j];
      ry = rem_y[j]; ly = lo_y[j]; qy = q_y[j];
      sx = '0; sy = '0;
      for (int b = 0; b < STEPS; b++) begin
        sx = div_step(rx, lx[WORD_W-1], d[j]);
        sy = div_step(ry, ly[WORD_W-1], d[j]);
        rx = sx[WORD_W-1:0];
        ry = sy[WORD_W-1:0];
        lx = {lx[WORD_W-2:0], 1'b0};
        ly = {ly[WORD_W-2:0], 1'b0};
        qx = {qx[WORD_W-2:0], sx[WORD_W]};
        qy = {qy[WORD_W-2:0], sy[WORD_W]};
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        side[j+1].valid <= 1'b0;
      end else if (en) begin
        side[j+1].valid <= side[j].valid;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        side[j+1].vis   <= side[j].vis;
        side[j+1].idx   <= side[j].idx;
        side[j+1].neg_x <= side[j].neg_x;
        side[j+1].neg_y <= side[j].neg_y;
        side[j+1].ovf_x <= side[j].ovf_x;
        side[j+1].ovf_y <= side[j].ovf_y;
        d[j+1]     <= d[j];
        rem_x[j+1] <= rx;
        lo_x[j+1]  <= lx;
        q_x[j+1]   <= qx;
        rem_y[j+1] <= ry;
        lo_y[j+1]  <= ly;
        q_y[j+1]   <= qy;
      end
    end
  end

  assign side_out = side[STAGES];
  assign quot_x   = q_x[STAGES];
  assign quot_y   = q_y[STAGES];

endmodule
